### design/tsc_pkg.sv
// ----------------------------------------------------------------------------
// tsc_pkg: shared types and constants of the text stream classifier
// Byte codes, mark bytes, UTF-8 range codes, line style codes and the
// control struct that steps the per-file tracking units.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned OUT_BITS       = 32;
  localparam int unsigned CFG_BITS       = 21;
  // one bit more than the window so that a saturated position compares above any window
  localparam int unsigned POS_BITS       = CFG_BITS + 1;

  localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(8192);

  localparam logic [7:0] LF_BYTE   = 8'h0A;
  localparam logic [7:0] CR_BYTE   = 8'h0D;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  localparam logic [7:0] MARK_BYTE0 = 8'hEF;
  localparam logic [7:0] MARK_BYTE1 = 8'hBB;
  localparam logic [7:0] MARK_BYTE2 = 8'hBF;

  // range of the next UTF-8 continuation byte
  localparam logic [2:0] RNG_80BF = 3'd0;
  localparam logic [2:0] RNG_A0BF = 3'd1;
  localparam logic [2:0] RNG_809F = 3'd2;
  localparam logic [2:0] RNG_90BF = 3'd3;
  localparam logic [2:0] RNG_808F = 3'd4;

  localparam logic [1:0] STYLE_LF    = 2'd0;
  localparam logic [1:0] STYLE_CRLF  = 2'd1;
  localparam logic [1:0] STYLE_MIXED = 2'd2;

  typedef struct packed {
    logic step;  // a byte is processed this cycle
    logic last;  // that byte ends the file
  } tsc_ctl_t;

  function automatic logic [7:0] mark_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = MARK_BYTE0;
      2'd1:    val = MARK_BYTE1;
      default: val = MARK_BYTE2;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

### design/tsc_utf8.sv
// ----------------------------------------------------------------------------
// tsc_utf8: UTF-8 validity tracker
// Follows multibyte sequences with a pending count and a range code for the
// next continuation byte; the error flag is sticky until the file ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_utf8 import tsc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tsc_ctl_t ctl,
  input  wire logic [7:0] data_byte,
  output logic          bad_utf8
);

  logic [1:0] left_r, left_nxt;
  logic [2:0] code_r, code_nxt;
  logic       err_r, err_nxt;
  logic [7:0] lo, hi;

  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    unique case (code_r)
      RNG_A0BF: lo = 8'hA0;
      RNG_809F: hi = 8'h9F;
      RNG_90BF: lo = 8'h90;
      RNG_808F: hi = 8'h8F;
      default: ;
    endcase
  end

  always_comb begin
    left_nxt = left_r;
    code_nxt = code_r;
    err_nxt  = err_r;
    if (left_r != 2'd0) begin
      code_nxt = RNG_80BF;
      if (data_byte < lo || data_byte > hi) begin
        err_nxt  = 1'b1;
        left_nxt = 2'd0;
      end else begin
        left_nxt = left_r - 2'd1;
      end
    end else if (data_byte[7]) begin
      if (data_byte >= 8'hC2 && data_byte <= 8'hDF) begin
        left_nxt = 2'd1;
      end else if (data_byte == 8'hE0) begin
        left_nxt = 2'd2;
        code_nxt = RNG_A0BF;
      end else if (data_byte == 8'hED) begin
        left_nxt = 2'd2;
        code_nxt = RNG_809F;
      end else if (data_byte >= 8'hE1 && data_byte <= 8'hEF) begin
        left_nxt = 2'd2;
      end else if (data_byte == 8'hF0) begin
        left_nxt = 2'd3;
        code_nxt = RNG_90BF;
      end else if (data_byte >= 8'hF1 && data_byte <= 8'hF3) begin
        left_nxt = 2'd3;
      end else if (data_byte == 8'hF4) begin
        left_nxt = 2'd3;
        code_nxt = RNG_808F;
      end else begin
        err_nxt = 1'b1;
      end
    end
  end

  // an open sequence at the end of the file counts as invalid
  assign bad_utf8 = err_nxt || (left_nxt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 2'd0;
      code_r <= RNG_80BF;
      err_r  <= 1'b0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        left_r <= 2'd0;
        code_r <= RNG_80BF;
        err_r  <= 1'b0;
      end else begin
        left_r <= left_nxt;
        code_r <= code_nxt;
        err_r  <= err_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### design/tsc_eol.sv
// ----------------------------------------------------------------------------
// tsc_eol: line ending counter
// Counts CRLF and bare LF endings with saturating counters and derives the
// line style and dominant style for the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_eol import tsc_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tsc_ctl_t            ctl,
  input  wire logic [7:0]          data_byte,
  output logic [OUT_BITS-1:0]      crlf_total,
  output logic [OUT_BITS-1:0]      lf_total,
  output logic [1:0]               line_style,
  output logic                     dominant_style
);

  localparam logic [COUNT_BITS-1:0] OUT_CAP = COUNT_BITS'({OUT_BITS{1'b1}});

  logic [7:0]            prev_r;
  logic [COUNT_BITS-1:0] crlf_r, crlf_nxt;
  logic [COUNT_BITS-1:0] lf_r, lf_nxt;
  logic                  is_lf;

  assign is_lf = (data_byte == LF_BYTE);

  always_comb begin
    crlf_nxt = crlf_r;
    lf_nxt   = lf_r;
    if (is_lf) begin
      if (prev_r == CR_BYTE) begin
        if (!(&crlf_r)) crlf_nxt = crlf_r + COUNT_BITS'(1);
      end else begin
        if (!(&lf_r)) lf_nxt = lf_r + COUNT_BITS'(1);
      end
    end
  end

  always_comb begin
    dominant_style = (crlf_nxt > lf_nxt);
    if (crlf_nxt != '0 && lf_nxt != '0) begin
      line_style = STYLE_MIXED;
    end else if (dominant_style) begin
      line_style = STYLE_CRLF;
    end else begin
      line_style = STYLE_LF;
    end
    // clip wide counters to the result width
    crlf_total = (crlf_nxt > OUT_CAP) ? {OUT_BITS{1'b1}} : OUT_BITS'(crlf_nxt);
    lf_total   = (lf_nxt > OUT_CAP) ? {OUT_BITS{1'b1}} : OUT_BITS'(lf_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 8'h00;
      crlf_r <= '0;
      lf_r   <= '0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        prev_r <= 8'h00;
        crlf_r <= '0;
        lf_r   <= '0;
      end else begin
        prev_r <= data_byte;
        crlf_r <= crlf_nxt;
        lf_r   <= lf_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### design/text_stream_classifier.sv
// ----------------------------------------------------------------------------
// text_stream_classifier: line ending and encoding detection over a byte stream
// Result path: a final byte passes the input register, then the result register.
// Throughput: one byte per cycle; input stalls only while a final byte waits
//   for a result register that still holds an untaken result.
// Reset: synchronous, active low; clears file state and valids, window = 8192.
// ----------------------------------------------------------------------------
`default_nettype none

module text_stream_classifier import tsc_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_BITS-1:0] cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_final_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_is_binary,
  output logic                     out_has_bom,
  output logic [OUT_BITS-1:0]      out_crlf_total,
  output logic [OUT_BITS-1:0]      out_lf_total,
  output logic [1:0]               out_line_style,
  output logic                     out_dominant_style,
  output logic                     out_bad_utf8,
  output logic                     out_no_final_newline
);

  logic [CFG_BITS-1:0] win_r;

  logic       a_valid_r;
  logic [7:0] a_byte_r;
  logic       a_last_r;
  logic       a_adv;
  tsc_ctl_t   ctl;

  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [1:0]          mprog_r, mprog_nxt;
  logic                mseen_r, mseen_nxt;
  logic                zero_r, zero_nxt;
  logic                empty;
  logic                not_lf;

  logic [OUT_BITS-1:0] crlf_total, lf_total;
  logic [1:0]          line_style;
  logic                dominant_style;
  logic                bad_utf8;

  logic                out_valid_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      win_r <= cfg_wr_data;
    end
  end

  // input stage: a final byte waits here until the result register is free
  assign a_adv    = a_valid_r && (!a_last_r || !out_valid_r || out_ready);
  assign in_ready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte_r <= in_data_byte;
      a_last_r <= in_final_byte;
    end
  end

  assign ctl.step = a_adv;
  assign ctl.last = a_last_r;

  // position, mark and zero-byte tracking
  always_comb begin
    pos_nxt   = (&pos_r) ? pos_r : pos_r + POS_BITS'(1);
    zero_nxt  = zero_r || (a_byte_r == ZERO_BYTE && pos_r < POS_BITS'(win_r));
    mprog_nxt = mprog_r;
    mseen_nxt = mseen_r;
    if (pos_r < POS_BITS'(3) && mprog_r == pos_r[1:0] && !mseen_r &&
        a_byte_r == mark_byte(pos_r[1:0])) begin
      if (pos_r[1:0] == 2'd2) mseen_nxt = 1'b1;
      else                    mprog_nxt = mprog_r + 2'd1;
    end
    empty  = mseen_nxt && (pos_nxt == POS_BITS'(3));
    not_lf = (a_byte_r != LF_BYTE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      mprog_r <= 2'd0;
      mseen_r <= 1'b0;
      zero_r  <= 1'b0;
    end else if (a_adv) begin
      if (a_last_r) begin
        pos_r   <= '0;
        mprog_r <= 2'd0;
        mseen_r <= 1'b0;
        zero_r  <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        mprog_r <= mprog_nxt;
        mseen_r <= mseen_nxt;
        zero_r  <= zero_nxt;
      end
    end
  end

  tsc_utf8 u_utf8 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .data_byte (a_byte_r),
    .bad_utf8  (bad_utf8)
  );

  tsc_eol #(
    .COUNT_BITS (COUNT_BITS)
  ) u_eol (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .data_byte      (a_byte_r),
    .crlf_total     (crlf_total),
    .lf_total       (lf_total),
    .line_style     (line_style),
    .dominant_style (dominant_style)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_adv && a_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_last_r) begin
      if (zero_nxt) begin
        // binary file: only the missing newline check survives
        out_is_binary        <= 1'b1;
        out_has_bom          <= 1'b0;
        out_crlf_total       <= '0;
        out_lf_total         <= '0;
        out_line_style       <= STYLE_LF;
        out_dominant_style   <= 1'b0;
        out_bad_utf8         <= 1'b0;
        out_no_final_newline <= not_lf;
      end else begin
        out_is_binary        <= 1'b0;
        out_has_bom          <= mseen_nxt;
        out_crlf_total       <= crlf_total;
        out_lf_total         <= lf_total;
        out_line_style       <= line_style;
        out_dominant_style   <= dominant_style;
        out_bad_utf8         <= bad_utf8;
        out_no_final_newline <= !empty && not_lf;
      end
    end
  end

  assign out_valid = out_valid_r;

  // assertions
  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && a_last_r) |=> out_valid)
    else $error("final byte processed without a result");

  a_stall_only_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (a_valid_r && a_last_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked final byte");

  a_binary_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_binary) |->
      (out_crlf_total == '0 && out_lf_total == '0 && !out_has_bom && !out_bad_utf8))
    else $error("binary result carries text fields");

  a_mixed_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_style == STYLE_MIXED) |->
      (out_crlf_total != '0 && out_lf_total != '0))
    else $error("mixed style without both endings");

endmodule

`default_nettype wire

### verif/tb_text_stream_classifier.sv
// ----------------------------------------------------------------------------
// tb_text_stream_classifier: self-checking bench for the text stream classifier
// Files are sent one byte per item. Each accepted byte also goes through a
// local model of the classifier, and the verdict for each file is checked
// field by field against the block's result. The run starts with short
// directed files (byte order mark, binary files, line endings, UTF-8 errors,
// window edges) and then sends random files, mostly well-formed text, with
// random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_text_stream_classifier;
  import tsc_pkg::*;

  localparam int unsigned COUNT_W      = COUNT_BITS_DEF;
  localparam int unsigned DUT_LATENCY  = 2;
  localparam int unsigned RANDOM_BYTES = 1750;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam logic [7:0]  BOM_SEQ [3]  = '{MARK_BYTE0, MARK_BYTE1, MARK_BYTE2};

  typedef struct {
    logic                is_binary;
    logic                has_bom;
    logic [OUT_BITS-1:0] crlf_total;
    logic [OUT_BITS-1:0] lf_total;
    logic [1:0]          line_style;
    logic                dominant_style;
    logic                bad_utf8;
    logic                no_final_newline;
  } file_verdict_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CFG_BITS-1:0] cfg_wr_data;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_data_byte;
  logic                in_final_byte;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_is_binary;
  logic                out_has_bom;
  logic [OUT_BITS-1:0] out_crlf_total;
  logic [OUT_BITS-1:0] out_lf_total;
  logic [1:0]          out_line_style;
  logic                out_dominant_style;
  logic                out_bad_utf8;
  logic                out_no_final_newline;

  // model state of the file in progress
  logic [CFG_BITS-1:0] window_reg;
  logic [31:0]         pos_count;
  logic [7:0]          prev_byte;
  logic [1:0]          mark_step;
  logic                mark_found;
  logic                zero_found;
  logic [COUNT_W-1:0]  crlf_tally;
  logic [COUNT_W-1:0]  lf_tally;
  logic [1:0]          utf_left;
  logic [2:0]          utf_rng;
  logic                utf_bad;

  file_verdict_t verdicts_due[$];
  logic [7:0]    text_buf[$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  int unsigned   stall_left = 0;
  bit            quiet_tail;
  bit            tx_gaps;
  bit            rx_stalls = 1'b1;

  text_stream_classifier DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_data_byte        (in_data_byte),
    .in_final_byte       (in_final_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_is_binary       (out_is_binary),
    .out_has_bom         (out_has_bom),
    .out_crlf_total      (out_crlf_total),
    .out_lf_total        (out_lf_total),
    .out_line_style      (out_line_style),
    .out_dominant_style  (out_dominant_style),
    .out_bad_utf8        (out_bad_utf8),
    .out_no_final_newline(out_no_final_newline)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_text_stream_classifier: FAIL");
      $finish;
    end
  end

  // result side: random stall bursts, none in the tail
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!quiet_tail && rx_stalls && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
    if (cycle_count % 150 == 0) rx_stalls <= ($urandom_range(0, 2) != 0);
  end

  function automatic void clear_tracking();
    pos_count  = '0;
    prev_byte  = '0;
    mark_step  = '0;
    mark_found = 1'b0;
    zero_found = 1'b0;
    crlf_tally = '0;
    lf_tally   = '0;
    utf_left   = '0;
    utf_rng    = RNG_80BF;
    utf_bad    = 1'b0;
  endfunction

  function automatic logic [OUT_BITS-1:0] clip_count(logic [COUNT_W-1:0] v);
    return (64'(v) > 64'hFFFF_FFFF) ? '1 : OUT_BITS'(v);
  endfunction

  function automatic void track_utf8(logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    if (utf_left != 0) begin
      lo = 8'h80;
      hi = 8'hBF;
      case (utf_rng)
        RNG_A0BF: lo = 8'hA0;
        RNG_809F: hi = 8'h9F;
        RNG_90BF: lo = 8'h90;
        RNG_808F: hi = 8'h8F;
        default: ;
      endcase
      if (b < lo || b > hi) begin
        utf_bad  = 1'b1;
        utf_left = '0;
      end else begin
        utf_left = utf_left - 2'd1;
      end
      utf_rng = RNG_80BF;
    end else if (b >= 8'h80) begin
      if (b >= 8'hC2 && b <= 8'hDF) begin
        utf_left = 2'd1;
      end else if (b == 8'hE0) begin
        utf_left = 2'd2;
        utf_rng  = RNG_A0BF;
      end else if (b == 8'hED) begin
        utf_left = 2'd2;
        utf_rng  = RNG_809F;
      end else if (b >= 8'hE1 && b <= 8'hEF) begin
        utf_left = 2'd2;
      end else if (b == 8'hF0) begin
        utf_left = 2'd3;
        utf_rng  = RNG_90BF;
      end else if (b >= 8'hF1 && b <= 8'hF3) begin
        utf_left = 2'd3;
      end else if (b == 8'hF4) begin
        utf_left = 2'd3;
        utf_rng  = RNG_808F;
      end else begin
        utf_bad = 1'b1;
      end
    end
  endfunction

  // advance the model by one accepted byte; a final byte yields a verdict
  function automatic void classify_byte(logic [7:0] b, logic last);
    file_verdict_t v;
    logic          crlf_wins;
    logic          both_styles;
    if (b == ZERO_BYTE && pos_count < 32'(window_reg)) zero_found = 1'b1;
    if (pos_count < 3 && 32'(mark_step) == pos_count && !mark_found) begin
      if (b == BOM_SEQ[mark_step]) begin
        if (mark_step == 2'd2) mark_found = 1'b1;
        else mark_step = mark_step + 2'd1;
      end
    end
    if (b == LF_BYTE) begin
      if (prev_byte == CR_BYTE) begin
        if (crlf_tally != '1) crlf_tally = crlf_tally + COUNT_W'(1);
      end else if (lf_tally != '1) begin
        lf_tally = lf_tally + COUNT_W'(1);
      end
    end
    track_utf8(b);
    prev_byte = b;
    if (pos_count != '1) pos_count = pos_count + 32'd1;
    if (!last) return;

    if (zero_found) begin
      v.is_binary        = 1'b1;
      v.has_bom          = 1'b0;
      v.crlf_total       = '0;
      v.lf_total         = '0;
      v.line_style       = STYLE_LF;
      v.dominant_style   = 1'b0;
      v.bad_utf8         = 1'b0;
      v.no_final_newline = (b != LF_BYTE);
    end else begin
      crlf_wins          = (crlf_tally > lf_tally);
      both_styles        = (crlf_tally != 0 && lf_tally != 0);
      v.is_binary        = 1'b0;
      v.has_bom          = mark_found;
      v.crlf_total       = clip_count(crlf_tally);
      v.lf_total         = clip_count(lf_tally);
      v.line_style       = both_styles ? STYLE_MIXED : (crlf_wins ? STYLE_CRLF : STYLE_LF);
      v.dominant_style   = crlf_wins;
      v.bad_utf8         = utf_bad || (utf_left != 0);
      // a file that is only the mark has no content
      v.no_final_newline = !(mark_found && pos_count == 3) && (b != LF_BYTE);
    end
    verdicts_due.push_back(v);
    clear_tracking();
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    file_verdict_t v;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual crlf %0h lf %0h",
                 $time, out_crlf_total, out_lf_total);
      end else begin
        v = verdicts_due.pop_front();
        check_field("is_binary", 32'(v.is_binary), 32'(out_is_binary));
        check_field("has_bom", 32'(v.has_bom), 32'(out_has_bom));
        check_field("crlf_total", v.crlf_total, out_crlf_total);
        check_field("lf_total", v.lf_total, out_lf_total);
        check_field("line_style", 32'(v.line_style), 32'(out_line_style));
        check_field("dominant_style", 32'(v.dominant_style), 32'(out_dominant_style));
        check_field("bad_utf8", 32'(v.bad_utf8), 32'(out_bad_utf8));
        check_field("no_final_newline", 32'(v.no_final_newline), 32'(out_no_final_newline));
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    gap = 0;
    if (!quiet_tail && tx_gaps && $urandom_range(0, 6) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    classify_byte(b, last);
  endtask

  // hold the sender until every verdict is back and the pipeline is empty
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DUT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic set_window(logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    window_reg = value;
  endtask

  task automatic test_mark();
    send_byte(MARK_BYTE0, 1'b0);
    send_byte(MARK_BYTE1, 1'b0);
    send_byte(MARK_BYTE2, 1'b1);
    // broken mark falls back to content and fails as UTF-8
    send_byte(MARK_BYTE0, 1'b0);
    send_byte(MARK_BYTE1, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_binary();
    send_byte(ZERO_BYTE, 1'b0);
    send_byte(8'h41, 1'b1);
  endtask

  task automatic test_line_endings();
    send_byte(CR_BYTE, 1'b0);
    send_byte(LF_BYTE, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(CR_BYTE, 1'b0);
    send_byte(LF_BYTE, 1'b0);
    send_byte(LF_BYTE, 1'b1);
  endtask

  task automatic test_utf8_errors();
    // sequence left open at the end of the file
    send_byte(8'hE0, 1'b0);
    send_byte(8'hA0, 1'b1);
    // surrogate range after ED
    send_byte(8'hED, 1'b0);
    send_byte(8'hA0, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_window_edges();
    wait_idle();
    set_window('0);
    send_byte(ZERO_BYTE, 1'b0);
    send_byte(LF_BYTE, 1'b1);
    wait_idle();
    set_window(CFG_BITS'(1));
    send_byte(8'h41, 1'b0);
    // widen the window in the middle of a file
    wait_idle();
    set_window(CFG_BITS'(2));
    send_byte(ZERO_BYTE, 1'b1);
    wait_idle();
    set_window(CFG_BITS'(1048576));
    send_byte(ZERO_BYTE, 1'b1);
  endtask

  function automatic logic [CFG_BITS-1:0] pick_window();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CFG_BITS'(1);
      2:       return CFG_BITS'($urandom_range(2, 40));
      3:       return WINDOW_RESET;
      4:       return CFG_BITS'(1048576);
      5:       return CFG_BITS'($urandom_range(0, 1048576));
      default: return CFG_BITS'($urandom_range(0, 12));
    endcase
  endfunction

  function automatic void add_piece(bit noisy);
    logic [7:0] lead;
    case ($urandom_range(0, noisy ? 15 : 11))
      0, 1, 2, 3, 4, 5: text_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
      6: text_buf.push_back(LF_BYTE);
      7: begin
        text_buf.push_back(CR_BYTE);
        text_buf.push_back(LF_BYTE);
      end
      8: text_buf.push_back(CR_BYTE);
      9: begin
        text_buf.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
      10: begin
        lead = 8'($urandom_range(8'hE0, 8'hEF));
        text_buf.push_back(lead);
        if (lead == 8'hE0) text_buf.push_back(8'($urandom_range(8'hA0, 8'hBF)));
        else if (lead == 8'hED) text_buf.push_back(8'($urandom_range(8'h80, 8'h9F)));
        else text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
        text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
      11: begin
        lead = 8'($urandom_range(8'hF0, 8'hF4));
        text_buf.push_back(lead);
        if (lead == 8'hF0) text_buf.push_back(8'($urandom_range(8'h90, 8'hBF)));
        else if (lead == 8'hF4) text_buf.push_back(8'($urandom_range(8'h80, 8'h8F)));
        else text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
        repeat (2) text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
      12: begin
        // lead byte followed by a plain byte instead of a continuation
        text_buf.push_back(8'($urandom_range(8'hC2, 8'hF4)));
        text_buf.push_back(8'($urandom_range(8'h01, 8'h7F)));
      end
      13: begin
        if ($urandom_range(0, 1)) text_buf.push_back(8'($urandom_range(8'h80, 8'hBF)));
        else if ($urandom_range(0, 1)) text_buf.push_back(8'($urandom_range(8'hC0, 8'hC1)));
        else text_buf.push_back(8'($urandom_range(8'hF5, 8'hFF)));
      end
      14: text_buf.push_back(ZERO_BYTE);
      default: text_buf.push_back(8'($urandom_range(0, 255)));
    endcase
  endfunction

  function automatic void build_text();
    bit noisy;
    noisy = ($urandom_range(0, 4) == 0);
    text_buf.delete();
    if ($urandom_range(0, 3) == 0) begin
      foreach (BOM_SEQ[i]) text_buf.push_back(BOM_SEQ[i]);
      if (noisy) repeat ($urandom_range(0, 2)) void'(text_buf.pop_back());
    end
    repeat ($urandom_range(0, 24)) add_piece(noisy);
    if ($urandom_range(0, 2) == 0) text_buf.push_back(LF_BYTE);
    if (noisy && $urandom_range(0, 2) == 0) text_buf.push_back(8'($urandom_range(8'hC2, 8'hF4)));
    if (text_buf.size() == 0) text_buf.push_back(8'h41);
  endfunction

  task automatic test_random_files();
    int unsigned sent;
    int unsigned files;
    sent  = 0;
    files = 0;
    while (sent < RANDOM_BYTES) begin
      if (sent > RANDOM_BYTES * 85 / 100) quiet_tail = 1'b1;
      if (files % 6 == 0 && !quiet_tail) begin
        wait_idle();
        set_window(pick_window());
      end
      tx_gaps = ($urandom_range(0, 3) != 0);
      build_text();
      foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
      sent += text_buf.size();
      files++;
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_final_byte = 1'b0;
    quiet_tail    = 1'b0;
    tx_gaps       = 1'b1;
    window_reg    = WINDOW_RESET;
    clear_tracking();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_mark();
    test_binary();
    test_line_endings();
    test_utf8_errors();
    test_window_edges();
    test_random_files();

    quiet_tail = 1'b1;
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DUT_LATENCY + 6) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_text_stream_classifier: PASS");
    end else begin
      $display("tb_text_stream_classifier: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
